/* hdl/uva_pkg.sv */
package uva_pkg;

   // Sizing
   localparam int NUM_VOICES = 8;
   localparam int MAX_NOTES  = 16;

   // Field widths
   localparam int ID_W    = 16;
   localparam int PITCH_W = 7;
   localparam int VEL_W   = 7;
   localparam int VOICE_W = 4;

   // Derived widths
   localparam int VIDX_W = $clog2(NUM_VOICES);
   localparam int ASG_W  = $clog2(NUM_VOICES + 1);
   localparam int IDX_W  = $clog2(MAX_NOTES);
   localparam int CNT_W  = $clog2(MAX_NOTES + 1);
   localparam int CMP_W  = ((CNT_W > ASG_W) ? CNT_W : ASG_W) + 1;

   // Queue depths
   localparam int REQ_DEPTH = 2;
   localparam int REQ_PTR_W = $clog2(REQ_DEPTH);
   localparam int REQ_CNT_W = $clog2(REQ_DEPTH + 1);
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PITCH_W-1:0] pitch;
      logic [VEL_W-1:0]   vel;
      logic               off;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PITCH_W-1:0] pitch;
      logic [VEL_W-1:0]   vel;
      logic [VOICE_W-1:0] voice;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DIV,
      ST_TGT,
      ST_FREE,
      ST_CHK,
      ST_SORT,
      ST_FIND,
      ST_STEAL,
      ST_SETF2,
      ST_OFF_EMIT,
      ST_OFF_SHIFT,
      ST_FINISH
   } state_type;

   // Map a voice index to its 1-based voice number, masked to the port width
   function automatic logic [VOICE_W-1:0] voice_num(input logic [VIDX_W-1:0] v);
      logic [VIDX_W:0] t;
      t = {1'b0, v} + 1'b1;
      return VOICE_W'(t);
   endfunction

endpackage

/* hdl/uva_req_queue.sv */
module uva_req_queue
   import uva_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [ID_W-1:0]    note_id,
   input  logic [PITCH_W-1:0] pitch,
   input  logic [VEL_W-1:0]   velocity,
   input  logic               pop,
   output logic               empty,
   output req_type            req_out
);

   req_type                store_ff [REQ_DEPTH];
   logic [REQ_PTR_W-1:0]   wr_ff, wr_in;
   logic [REQ_PTR_W-1:0]   rd_ff, rd_in;
   logic [REQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   do_push, do_pop;
   req_type                item;

   assign full    = (cnt_ff == REQ_CNT_W'(REQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign req_out = store_ff[rd_ff];

   // Classify the request: zero velocity is a note-off
   always_comb begin
      item.id    = note_id;
      item.pitch = pitch;
      item.vel   = velocity;
      item.off   = (velocity == '0);
   end

   // Advance pointers and fill count
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the request
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= item;
      end
   end

endmodule

/* hdl/uva_rsp_queue.sv */
module uva_rsp_queue
   import uva_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  rsp_type rsp_in,
   input  logic pop,
   output logic empty,
   output rsp_type rsp_out
);

   rsp_type                store_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ff, wr_in;
   logic [RSP_PTR_W-1:0]   rd_ff, rd_in;
   logic [RSP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign full    = (cnt_ff == RSP_CNT_W'(RSP_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rsp_out = store_ff[rd_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the result
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= rsp_in;
      end
   end

endmodule

/* hdl/uva_engine.sv */
module uva_engine
   import uva_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_empty,
   input  req_type req_in,
   output logic    req_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_out
);

   // Note table
   logic [ID_W-1:0]    id_ff    [MAX_NOTES];
   logic [PITCH_W-1:0] pitch_ff [MAX_NOTES];
   logic [VEL_W-1:0]   vel_ff   [MAX_NOTES];
   logic [ASG_W-1:0]   asg_ff   [MAX_NOTES];
   logic [ASG_W-1:0]   req_ff   [MAX_NOTES];
   logic [NUM_VOICES-1:0][VIDX_W-1:0] stk_ff [MAX_NOTES];
   logic [CNT_W-1:0]   count_ff;
   logic [NUM_VOICES-1:0] busy_ff;

   // Sequencer
   state_type          state_ff, state_in;
   req_type            cur_ff;
   logic [IDX_W-1:0]   e_ff;
   logic [ASG_W-1:0]   q_ff, r_ff;
   logic [ASG_W-1:0]   target_ff, need_ff, left_ff, k_ff;
   logic [VIDX_W-1:0]  vscan_ff;
   logic               second_ff;
   logic [IDX_W-1:0]   pass_ff;
   logic [CNT_W-1:0]   si_ff;
   rsp_type            pend_ff;
   logic               pend_valid_ff;

   logic               hit_found;
   logic [IDX_W-1:0]   hit_idx;
   logic               go;
   logic               emit;
   rsp_type            emit_data;
   logic [IDX_W-1:0]   si_idx;
   logic [ASG_W-1:0]   si_req, e_req, si_top;
   logic               div_more;

   // Voices owed to the entry at position i under the current split
   function automatic logic [ASG_W-1:0] req_of(input logic [CNT_W-1:0] i,
                                               input logic [ASG_W-1:0] q,
                                               input logic [ASG_W-1:0] r,
                                               input logic [CNT_W-1:0] cnt);
      logic [CMP_W-1:0] sum;
      sum = CMP_W'(i) + CMP_W'(r);
      return q + ASG_W'(sum >= CMP_W'(cnt));
   endfunction

   assign si_idx   = si_ff[IDX_W-1:0];
   assign si_req   = req_ff[si_idx];
   assign e_req    = req_of(CNT_W'(e_ff), q_ff, r_ff, count_ff);
   assign si_top   = asg_ff[si_idx] - 1'b1;
   assign div_more = (CMP_W'(r_ff) >= CMP_W'(count_ff));
   assign go       = !(pend_valid_ff && rsp_full);

   // Search the held notes for the request id, lowest position wins
   always_comb begin
      hit_found = 1'b0;
      hit_idx   = '0;
      for (int i = MAX_NOTES - 1; i >= 0; i--) begin
         if ((CNT_W'(i) < count_ff) && (id_ff[i] == cur_ff.id)) begin
            hit_found = 1'b1;
            hit_idx   = IDX_W'(i);
         end
      end
   end

   // Select the voice message of this cycle
   always_comb begin
      emit      = 1'b0;
      emit_data = '0;
      case (state_ff)
         ST_FREE: begin
            emit            = (asg_ff[e_ff] < target_ff) && !busy_ff[vscan_ff];
            emit_data.id    = id_ff[e_ff];
            emit_data.pitch = pitch_ff[e_ff];
            emit_data.vel   = vel_ff[e_ff];
            emit_data.voice = voice_num(vscan_ff);
         end
         ST_STEAL: begin
            emit            = (si_ff < count_ff) && (left_ff != '0) &&
                              (asg_ff[si_idx] > si_req);
            emit_data.id    = id_ff[si_idx];
            emit_data.pitch = pitch_ff[si_idx];
            emit_data.voice = voice_num(stk_ff[si_idx][si_top[VIDX_W-1:0]]);
         end
         ST_OFF_EMIT: begin
            emit            = (k_ff < asg_ff[e_ff]);
            emit_data.id    = id_ff[e_ff];
            emit_data.pitch = pitch_ff[e_ff];
            emit_data.voice = voice_num(stk_ff[e_ff][k_ff[VIDX_W-1:0]]);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Hand the held message on; the final one of a request carries last
   always_comb begin
      rsp_push      = pend_valid_ff && !rsp_full && (emit || (state_ff == ST_FINISH));
      rsp_out       = pend_ff;
      rsp_out.last  = (state_ff == ST_FINISH);
   end

   assign req_pop = (state_ff == ST_IDLE) && !req_empty;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!req_empty) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (cur_ff.off) begin
               state_in = hit_found ? ST_OFF_EMIT : ST_FINISH;
            end else if (!hit_found && (count_ff == CNT_W'(MAX_NOTES))) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!div_more) state_in = ST_TGT;
         end
         ST_TGT: begin
            state_in = (e_req == '0) ? ST_FINISH : ST_FREE;
         end
         ST_FREE: begin
            if (go && (vscan_ff == VIDX_W'(NUM_VOICES - 1))) begin
               state_in = second_ff ? ST_FINISH : ST_CHK;
            end
         end
         ST_CHK: begin
            state_in = (asg_ff[e_ff] < target_ff) ? ST_SORT : ST_FINISH;
         end
         ST_SORT: begin
            if (pass_ff == IDX_W'(MAX_NOTES - 1)) state_in = ST_FIND;
         end
         ST_FIND: begin
            state_in = ST_STEAL;
         end
         ST_STEAL: begin
            if (go && ((si_ff >= count_ff) || (left_ff == '0))) state_in = ST_SETF2;
         end
         ST_SETF2: begin
            state_in = ST_FREE;
         end
         ST_OFF_EMIT: begin
            if (go && (k_ff >= asg_ff[e_ff])) state_in = ST_OFF_SHIFT;
         end
         ST_OFF_SHIFT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!pend_valid_ff || !rsp_full) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         busy_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit && go) begin
            pend_valid_ff <= 1'b1;
         end else if ((state_ff == ST_FINISH) && !rsp_full) begin
            pend_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_LOOKUP: begin
               if (!cur_ff.off && !hit_found && (count_ff != CNT_W'(MAX_NOTES))) begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            ST_FREE: begin
               if (go && emit) busy_ff[vscan_ff] <= 1'b1;
            end
            ST_STEAL: begin
               if (go && emit) busy_ff[stk_ff[si_idx][si_top[VIDX_W-1:0]]] <= 1'b0;
            end
            ST_OFF_EMIT: begin
               if (go && emit) busy_ff[stk_ff[e_ff][k_ff[VIDX_W-1:0]]] <= 1'b0;
            end
            ST_OFF_SHIFT: begin
               count_ff <= count_ff - 1'b1;
            end
            default: begin
               count_ff <= count_ff;
            end
         endcase
      end
   end

   // Table and work registers
   always_ff @(posedge clock) begin
      if (emit && go) begin
         pend_ff      <= emit_data;
      end
      case (state_ff)
         ST_IDLE: begin
            if (!req_empty) cur_ff <= req_in;
         end
         ST_LOOKUP: begin
            k_ff <= '0;
            q_ff <= '0;
            r_ff <= ASG_W'(NUM_VOICES);
            if (hit_found) begin
               e_ff <= hit_idx;
            end else begin
               e_ff <= count_ff[IDX_W-1:0];
               if (!cur_ff.off && (count_ff != CNT_W'(MAX_NOTES))) begin
                  id_ff[count_ff[IDX_W-1:0]]    <= cur_ff.id;
                  pitch_ff[count_ff[IDX_W-1:0]] <= cur_ff.pitch;
                  vel_ff[count_ff[IDX_W-1:0]]   <= cur_ff.vel;
                  asg_ff[count_ff[IDX_W-1:0]]   <= '0;
               end
            end
         end
         ST_DIV: begin
            // Split the voices by repeated subtraction
            if (div_more) begin
               r_ff <= ASG_W'(CMP_W'(r_ff) - CMP_W'(count_ff));
               q_ff <= q_ff + 1'b1;
            end
         end
         ST_TGT: begin
            target_ff <= e_req;
            vscan_ff  <= '0;
            second_ff <= 1'b0;
            // Record each entry's share; it travels with the entry in the sort
            for (int i = 0; i < MAX_NOTES; i++) begin
               req_ff[i] <= req_of(CNT_W'(i), q_ff, r_ff, count_ff);
            end
         end
         ST_FREE: begin
            if (go) begin
               vscan_ff <= vscan_ff + 1'b1;
               if (emit) begin
                  stk_ff[e_ff][asg_ff[e_ff][VIDX_W-1:0]] <= vscan_ff;
                  asg_ff[e_ff] <= asg_ff[e_ff] + 1'b1;
               end
            end
         end
         ST_CHK: begin
            need_ff <= target_ff - asg_ff[e_ff];
            left_ff <= target_ff - asg_ff[e_ff];
            pass_ff <= '0;
         end
         ST_SORT: begin
            // One odd-even transposition pass over the held notes
            for (int j = 0; j < MAX_NOTES - 1; j++) begin
               if ((j % 2 == int'(pass_ff[0])) && (CNT_W'(j + 1) < count_ff) &&
                   (id_ff[j] > id_ff[j+1])) begin
                  id_ff[j]      <= id_ff[j+1];
                  id_ff[j+1]    <= id_ff[j];
                  pitch_ff[j]   <= pitch_ff[j+1];
                  pitch_ff[j+1] <= pitch_ff[j];
                  vel_ff[j]     <= vel_ff[j+1];
                  vel_ff[j+1]   <= vel_ff[j];
                  asg_ff[j]     <= asg_ff[j+1];
                  asg_ff[j+1]   <= asg_ff[j];
                  req_ff[j]     <= req_ff[j+1];
                  req_ff[j+1]   <= req_ff[j];
                  stk_ff[j]     <= stk_ff[j+1];
                  stk_ff[j+1]   <= stk_ff[j];
               end
            end
            pass_ff <= pass_ff + 1'b1;
         end
         ST_FIND: begin
            e_ff  <= hit_idx;
            si_ff <= '0;
         end
         ST_STEAL: begin
            // Take surplus voices one at a time, newest first
            if (go && (si_ff < count_ff) && (left_ff != '0)) begin
               if (emit) begin
                  asg_ff[si_idx] <= si_top;
                  left_ff        <= left_ff - 1'b1;
               end else begin
                  si_ff <= si_ff + 1'b1;
               end
            end
         end
         ST_SETF2: begin
            target_ff <= asg_ff[e_ff] + (need_ff - left_ff);
            vscan_ff  <= '0;
            second_ff <= 1'b1;
         end
         ST_OFF_EMIT: begin
            if (go && emit) k_ff <= k_ff + 1'b1;
         end
         ST_OFF_SHIFT: begin
            // Close the gap left by the released note
            for (int i = 0; i < MAX_NOTES - 1; i++) begin
               if (IDX_W'(i) >= e_ff) begin
                  id_ff[i]    <= id_ff[i+1];
                  pitch_ff[i] <= pitch_ff[i+1];
                  vel_ff[i]   <= vel_ff[i+1];
                  asg_ff[i]   <= asg_ff[i+1];
                  stk_ff[i]   <= stk_ff[i+1];
               end
            end
         end
         default: begin
            e_ff <= e_ff;
         end
      endcase
   end

endmodule

/* hdl/unison_voice_allocator.sv */
// Unison voice allocator: note events go in through a two-deep request queue,
// voice start and stop messages come out through a four-deep result queue,
// one message per voice started or stopped, with last set on the final
// message of an event. A sequencer handles one event at a time: a note-off
// looks up the note, releases each of its voices and closes the gap in the
// table; a note-on looks up or enters the note, splits the voices by repeated
// subtraction and takes free voices for its share. When voices must be
// stolen, it sorts the table by id, takes surplus voices from the other
// notes and scans the free voices a second time.
// A full result queue stalls the sequencer while requests keep queueing.
module unison_voice_allocator
   import uva_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [ID_W-1:0]    req_note_id,
   input  logic [PITCH_W-1:0] req_pitch,
   input  logic [VEL_W-1:0]   req_velocity,
   output logic               empty,
   input  logic               pop,
   output logic [ID_W-1:0]    rsp_out_note_id,
   output logic [PITCH_W-1:0] rsp_out_pitch,
   output logic [VEL_W-1:0]   rsp_out_velocity,
   output logic [VOICE_W-1:0] rsp_out_voice,
   output logic               rsp_last
);

   req_type req_item;
   logic    req_empty, req_pop;
   rsp_type eng_rsp, rsp_item;
   logic    rsp_full, rsp_push;

   // Accept and classify requests
   uva_req_queue u_req (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .note_id  (req_note_id),
      .pitch    (req_pitch),
      .velocity (req_velocity),
      .pop      (req_pop),
      .empty    (req_empty),
      .req_out  (req_item)
   );

   // Allocate voices
   uva_engine u_eng (
      .clock     (clock),
      .reset     (reset),
      .req_empty (req_empty),
      .req_in    (req_item),
      .req_pop   (req_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_out   (eng_rsp)
   );

   // Hold results for the consumer
   uva_rsp_queue u_rsp (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .full    (rsp_full),
      .rsp_in  (eng_rsp),
      .pop     (pop),
      .empty   (empty),
      .rsp_out (rsp_item)
   );

   assign rsp_out_note_id  = rsp_item.id;
   assign rsp_out_pitch    = rsp_item.pitch;
   assign rsp_out_velocity = rsp_item.vel;
   assign rsp_out_voice    = rsp_item.voice;
   assign rsp_last         = rsp_item.last;

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(rsp_push && rsp_full))
      else $error("result pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(req_pop && req_empty))
      else $error("request popped from an empty queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result queue not empty after reset");
`endif

endmodule
